[rtl/core/sfd_pkg.sv]
package sfd_pkg;

    // defaults for the top-level parameters
    localparam int CHANNEL_COUNT_DEF = 18;
    localparam int COUNTER_BITS_DEF  = 32;

    // frame layout
    localparam int       FRAME_LEN   = 25;
    localparam int       CHAN_BITS   = 11;
    localparam int       PACKED_CH   = 16;
    localparam int       PACKED_BYTES = 22;
    localparam logic [7:0] START_MARK = 8'h0F;
    localparam logic [7:0] STOP_MARK  = 8'h00;

    // flag bits of the last data byte
    localparam int FLAG_CH16     = 0;
    localparam int FLAG_CH17     = 1;
    localparam int FLAG_LOST     = 2;
    localparam int FLAG_FAILSAFE = 3;

    localparam logic [CHAN_BITS-1:0] CH_FULL = 11'd2047;

    // scaling: (999 * (c - 200)) / 1600, 1600 = 64 * 25
    localparam logic [CHAN_BITS-1:0] SCALE_FROM  = 11'd200;
    localparam logic [9:0]           SCALE_MUL   = 10'd999;
    localparam logic [10:0]          SCALE_TOP   = 11'd999;
    localparam int                   DIV_SHIFT   = 6;
    localparam logic [12:0]          RECIP_25    = 13'd5243;
    localparam int                   RECIP_SHIFT = 17;

    // configuration registers
    localparam int                   CFG_IDX_W     = 4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LOW  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HIGH = 4'd1;
    localparam logic [CHAN_BITS-1:0] CLIP_LOW_RST  = 11'd200;
    localparam logic [CHAN_BITS-1:0] CLIP_HIGH_RST = 11'd1800;

    // depth of the queue between byte assembly and result generation
    localparam int QUEUE_DEPTH = 2;

    // one completed frame as handed from the front to the back
    typedef struct packed {
        logic                      frame_ok;
        logic [7:0]                flags;
        logic [PACKED_BYTES*8-1:0] chan_bits;
    } frame_rec_t;

    // one result travelling down the scaling pipeline
    typedef struct packed {
        logic [4:0]           chan_index;
        logic [CHAN_BITS-1:0] raw_value;
        logic                 frame_ok;
        logic                 failsafe_flag;
        logic [31:0]          lost_total;
        logic [31:0]          error_total;
        logic                 last_of_frame;
    } result_t;

endpackage

[rtl/core/sfd_front.sv]
module sfd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    input  logic                s_frame_start,
    input  logic                q_full,
    output logic                q_push,
    output sfd_pkg::frame_rec_t q_push_rec
);

    localparam int POS_W = $clog2(sfd_pkg::FRAME_LEN);

    logic [7:0]       byte_mem [sfd_pkg::FRAME_LEN-1];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] eff_pos;
    logic             beat;
    logic             complete;

    assign s_ready  = !q_full;
    assign beat     = s_valid && s_ready;
    assign eff_pos  = s_frame_start ? '0 : pos_reg;
    assign complete = (eff_pos == POS_W'(sfd_pkg::FRAME_LEN - 1));
    assign q_push   = beat && complete;

    always_comb begin
        pos_next = pos_reg;
        if (beat) begin
            pos_next = complete ? '0 : POS_W'(eff_pos + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // byte 24 is never stored, it is checked on the fly
    always_ff @(posedge aclk) begin
        if (beat && !complete) begin
            byte_mem[eff_pos] <= s_rx_byte;
        end
    end

    always_comb begin
        q_push_rec.frame_ok = (byte_mem[0] == sfd_pkg::START_MARK)
                              && (s_rx_byte == sfd_pkg::STOP_MARK);
        q_push_rec.flags    = byte_mem[sfd_pkg::PACKED_BYTES + 1];
        for (int i = 0; i < sfd_pkg::PACKED_BYTES; i++) begin
            q_push_rec.chan_bits[i*8 +: 8] = byte_mem[i + 1];
        end
    end

endmodule

[rtl/core/sfd_queue.sv]
module sfd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sfd_pkg::frame_rec_t push_rec,
    output logic                full,
    input  logic                pop,
    output logic                rd_valid,
    output sfd_pkg::frame_rec_t rd_rec
);

    localparam int DEPTH = sfd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfd_pkg::frame_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_rec   = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop) begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end else if (do_pop && !do_push) begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[rtl/core/sfd_back.sv]
module sfd_back #(
    parameter int CHANNEL_COUNT = sfd_pkg::CHANNEL_COUNT_DEF,
    parameter int COUNTER_BITS  = sfd_pkg::COUNTER_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [10:0]         clip_low,
    input  logic [10:0]         clip_high,
    input  logic                q_valid,
    input  sfd_pkg::frame_rec_t q_rec,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output sfd_pkg::result_t    m_result,
    output logic [9:0]          m_scaled
);

    localparam int IDX_W = $clog2(CHANNEL_COUNT);
    localparam int CW    = sfd_pkg::CHAN_BITS;

    // channel state and frame status
    logic [CW-1:0]           chan_reg [CHANNEL_COUNT];
    logic                    failsafe_reg;
    logic                    frame_ok_reg;
    logic [COUNTER_BITS-1:0] lost_reg;
    logic [COUNTER_BITS-1:0] err_reg;
    logic                    busy_reg;
    logic [IDX_W-1:0]        idx_reg;

    // scaling pipeline
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    sfd_pkg::result_t        s1_item_reg, s2_item_reg, s3_item_reg, out_item_reg;
    logic [CW-1:0]           s1_diff_reg;
    logic [20:0]             s2_prod_reg;
    logic [10:0]             s3_quot_reg;
    logic [9:0]              out_scaled_reg;

    logic                    adv;
    logic                    issue;
    logic                    last_issue;
    logic [CW-1:0]           cur_raw;
    logic [CW-1:0]           clip_a;
    logic [CW-1:0]           clip_b;
    logic [14:0]             s3_div_in;
    logic [27:0]             s3_recip;
    sfd_pkg::result_t        issue_item;

    assign adv        = !out_valid_reg || m_ready;
    assign issue      = busy_reg && adv;
    assign last_issue = (idx_reg == IDX_W'(CHANNEL_COUNT - 1));
    assign q_pop      = q_valid && (!busy_reg || (issue && last_issue));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CHANNEL_COUNT; k++) begin
                chan_reg[k] <= '0;
            end
            failsafe_reg <= 1'b0;
            frame_ok_reg <= 1'b0;
            lost_reg     <= '0;
            err_reg      <= '0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
        end else begin
            if (q_pop) begin
                busy_reg     <= 1'b1;
                idx_reg      <= '0;
                frame_ok_reg <= q_rec.frame_ok;
                if (q_rec.frame_ok) begin
                    for (int k = 0; k < CHANNEL_COUNT; k++) begin
                        if (k < sfd_pkg::PACKED_CH) begin
                            chan_reg[k] <= q_rec.chan_bits[k*CW +: CW];
                        end else if (k == sfd_pkg::PACKED_CH) begin
                            chan_reg[k] <= q_rec.flags[sfd_pkg::FLAG_CH16]
                                           ? sfd_pkg::CH_FULL : '0;
                        end else begin
                            chan_reg[k] <= q_rec.flags[sfd_pkg::FLAG_CH17]
                                           ? sfd_pkg::CH_FULL : '0;
                        end
                    end
                    failsafe_reg <= q_rec.flags[sfd_pkg::FLAG_FAILSAFE];
                    if (q_rec.flags[sfd_pkg::FLAG_LOST]) begin
                        lost_reg <= lost_reg + COUNTER_BITS'(1);
                    end
                end else begin
                    err_reg <= err_reg + COUNTER_BITS'(1);
                end
            end else if (issue) begin
                idx_reg <= last_issue ? '0 : IDX_W'(idx_reg + 1'b1);
                if (last_issue) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // issue stage: clip then offset
    assign cur_raw = chan_reg[idx_reg];
    assign clip_a  = (cur_raw < clip_low) ? clip_low : cur_raw;
    assign clip_b  = (clip_a > clip_high) ? clip_high : clip_a;

    always_comb begin
        issue_item.chan_index    = 5'(idx_reg);
        issue_item.raw_value     = cur_raw;
        issue_item.frame_ok      = frame_ok_reg;
        issue_item.failsafe_flag = failsafe_reg;
        issue_item.lost_total    = 32'(lost_reg);
        issue_item.error_total   = 32'(err_reg);
        issue_item.last_of_frame = last_issue;
    end

    // divide by 1600: shift right by 6 (divide by 64), then multiply by a reciprocal of 25
    assign s3_div_in = s2_prod_reg[20:sfd_pkg::DIV_SHIFT];
    assign s3_recip  = 28'(s3_div_in) * 28'(sfd_pkg::RECIP_25);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg    <= issue_item;
            s1_diff_reg    <= (clip_b > sfd_pkg::SCALE_FROM) ? CW'(clip_b - sfd_pkg::SCALE_FROM)
                                                             : '0;
            s2_item_reg    <= s1_item_reg;
            s2_prod_reg    <= 21'(s1_diff_reg) * 21'(sfd_pkg::SCALE_MUL);
            s3_item_reg    <= s2_item_reg;
            s3_quot_reg    <= s3_recip[27:sfd_pkg::RECIP_SHIFT];
            out_item_reg   <= s3_item_reg;
            out_scaled_reg <= (s3_quot_reg > sfd_pkg::SCALE_TOP) ? 10'(sfd_pkg::SCALE_TOP)
                                                                 : s3_quot_reg[9:0];
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_item_reg;
    assign m_scaled = out_scaled_reg;

endmodule

[rtl/core/sbus_frame_decoder.sv]
// sbus frame decoder
//
// input channel: one receiver byte per beat (s_rx_byte), s_frame_start forces
// the byte to be byte 0 of a new frame. the 25th byte of a frame completes it;
// the frame is good when byte 0 is 0x0f and byte 24 is 0x00.
// output channel: every completed frame yields CHANNEL_COUNT result beats,
// channel 0 first, m_last_of_frame on the final one. a bad frame repeats the
// channels of the last good frame and bumps the error count.
// config channel: cfg_index 0 writes clip_low, 1 writes clip_high, other
// indexes are dropped; cfg_ready is always high.
// throughput: one byte per cycle in while s_ready is high, one result per
// cycle out while m_ready is high. the front stalls (s_ready low) only
// when both frame slots of the queue are full. result path: frame queue,
// channel update, three scaling stages, output register; the rest of a
// frame follow back to back while m_ready is high.
// reset: byte position, channels, failsafe and both counters clear; clip
// bounds return to 200 and 1800.
// stalls: m_ready low with a result waiting freezes the whole scaling
// pipeline; bytes keep being taken until the queue fills.
module sbus_frame_decoder #(
    parameter int CHANNEL_COUNT = sfd_pkg::CHANNEL_COUNT_DEF,
    parameter int COUNTER_BITS  = sfd_pkg::COUNTER_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // byte input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          s_frame_start,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [10:0]                   cfg_data,
    // channel results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [4:0]                    m_chan_index,
    output logic [10:0]                   m_raw_value,
    output logic [9:0]                    m_scaled_value,
    output logic                          m_frame_ok,
    output logic                          m_failsafe_flag,
    output logic [31:0]                   m_lost_total,
    output logic [31:0]                   m_error_total,
    output logic                          m_last_of_frame
);

    logic [10:0]         clip_low_reg;
    logic [10:0]         clip_high_reg;
    logic                q_full;
    logic                q_push;
    logic                q_valid;
    logic                q_pop;
    sfd_pkg::frame_rec_t q_push_rec;
    sfd_pkg::frame_rec_t q_rd_rec;
    sfd_pkg::result_t    result;

    // config registers, to be written only while idle; the block itself does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_low_reg  <= sfd_pkg::CLIP_LOW_RST;
            clip_high_reg <= sfd_pkg::CLIP_HIGH_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sfd_pkg::REG_CLIP_LOW:  clip_low_reg  <= cfg_data;
                sfd_pkg::REG_CLIP_HIGH: clip_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // byte assembly and frame check
    sfd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .s_frame_start (s_frame_start),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_rec    (q_push_rec)
    );

    // completed frames waiting for the back end
    sfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (q_push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_rec   (q_rd_rec)
    );

    // channel state update and per-channel result pipeline
    sfd_back #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clip_low  (clip_low_reg),
        .clip_high (clip_high_reg),
        .q_valid   (q_valid),
        .q_rec     (q_rd_rec),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result),
        .m_scaled  (m_scaled_value)
    );

    assign m_chan_index    = result.chan_index;
    assign m_raw_value     = result.raw_value;
    assign m_frame_ok      = result.frame_ok;
    assign m_failsafe_flag = result.failsafe_flag;
    assign m_lost_total    = result.lost_total;
    assign m_error_total   = result.error_total;
    assign m_last_of_frame = result.last_of_frame;

endmodule

[rtl/core/sfd_checker.sv]
module sfd_checker #(
    parameter int CHANNEL_COUNT = sfd_pkg::CHANNEL_COUNT_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [4:0]  m_chan_index,
    input logic [10:0] m_raw_value,
    input logic [9:0]  m_scaled_value,
    input logic        m_frame_ok,
    input logic [31:0] m_lost_total,
    input logic [31:0] m_error_total,
    input logic        m_last_of_frame
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chan_index)
                                && $stable(m_raw_value) && $stable(m_scaled_value))
        else $error("result beat changed while stalled");

    // last flag only on the final channel
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_of_frame == (m_chan_index == 5'(CHANNEL_COUNT - 1))))
        else $error("last_of_frame does not match channel index");

    // channels of one frame follow without gaps, in order
    a_next_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_frame |=>
            m_valid && (m_chan_index == 5'($past(m_chan_index) + 5'd1)))
        else $error("channel beats of a frame not contiguous");

    // frame status is constant over the beats of one frame
    a_frame_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_frame |=>
            (m_error_total == $past(m_error_total)) && (m_frame_ok == $past(m_frame_ok))
            && (m_lost_total == $past(m_lost_total)))
        else $error("frame status changed within a frame");

    // scaled value saturates at 999
    a_scaled_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_scaled_value <= 10'd999)
        else $error("scaled value out of range");

endmodule

bind sbus_frame_decoder sfd_checker #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_sfd_checker (.*);

[dv/sbus_frame_decoder_checker.sv]
module sbus_frame_decoder_checker #(
    parameter int CHANNEL_COUNT = sfd_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          s_frame_start,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [10:0]                   cfg_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [4:0]                    m_chan_index,
    input  logic [10:0]                   m_raw_value,
    input  logic [9:0]                    m_scaled_value,
    input  logic                          m_frame_ok,
    input  logic                          m_failsafe_flag,
    input  logic [31:0]                   m_lost_total,
    input  logic [31:0]                   m_error_total,
    input  logic                          m_last_of_frame,
    output int                            fail_count,
    output int                            pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB         = sfd_pkg::CHAN_BITS;
    localparam int FL         = sfd_pkg::FRAME_LEN;
    localparam int PB         = sfd_pkg::PACKED_BYTES;
    localparam int SCALE_SPAN = 1600;

    typedef struct packed {
        logic [4:0]    chan_index;
        logic [CB-1:0] raw_value;
        logic [9:0]    scaled_value;
        logic          frame_ok;
        logic          failsafe_flag;
        logic [31:0]   lost_total;
        logic [31:0]   error_total;
        logic          last_of_frame;
    } chan_result_t;

    // decoder state mirrored here
    logic [4:0]    byte_pos;
    logic [7:0]    frame_buf [FL];
    logic [CB-1:0] chan_val [CHANNEL_COUNT];
    logic          failsafe_q;
    logic [31:0]   lost_cnt;
    logic [31:0]   err_cnt;
    logic [CB-1:0] clip_lo;
    logic [CB-1:0] clip_hi;

    chan_result_t expected_chans_q[$];

    function automatic logic [9:0] scale_chan(input logic [CB-1:0] v);
        int c;
        int s;
        c = int'(v);
        // low bound first, so crossed bounds end at clip_hi
        if (c < int'(clip_lo)) c = int'(clip_lo);
        if (c > int'(clip_hi)) c = int'(clip_hi);
        if (c <= int'(sfd_pkg::SCALE_FROM)) return '0;
        s = (int'(sfd_pkg::SCALE_MUL) * (c - int'(sfd_pkg::SCALE_FROM))) / SCALE_SPAN;
        if (s > int'(sfd_pkg::SCALE_TOP)) s = int'(sfd_pkg::SCALE_TOP);
        return 10'(s);
    endfunction

    task automatic decode_byte(input logic [7:0] rx, input logic start);
        logic [PB*8-1:0] packed_bits;
        logic [7:0]      flags;
        logic            good;
        chan_result_t    r;
        int              k;
        if (start) byte_pos = '0;
        if (byte_pos >= FL) byte_pos = '0;
        frame_buf[byte_pos] = rx;
        byte_pos = byte_pos + 5'd1;
        if (byte_pos < FL) return;
        byte_pos = '0;

        good = (frame_buf[0] == sfd_pkg::START_MARK)
               && (frame_buf[FL-1] == sfd_pkg::STOP_MARK);
        if (good) begin
            // channels packed lsb first starting at byte 1
            for (k = 0; k < PB; k++) packed_bits[k*8 +: 8] = frame_buf[k+1];
            for (k = 0; k < sfd_pkg::PACKED_CH; k++) chan_val[k] = packed_bits[k*CB +: CB];
            flags = frame_buf[PB+1];
            for (k = sfd_pkg::PACKED_CH; k < CHANNEL_COUNT; k++)
                chan_val[k] = flags[sfd_pkg::FLAG_CH16 + k - sfd_pkg::PACKED_CH]
                              ? sfd_pkg::CH_FULL : '0;
            failsafe_q = flags[sfd_pkg::FLAG_FAILSAFE];
            if (flags[sfd_pkg::FLAG_LOST]) lost_cnt = lost_cnt + 32'd1;
        end else begin
            err_cnt = err_cnt + 32'd1;
        end

        for (k = 0; k < CHANNEL_COUNT; k++) begin
            r.chan_index    = 5'(k);
            r.raw_value     = chan_val[k];
            r.scaled_value  = scale_chan(chan_val[k]);
            r.frame_ok      = good;
            r.failsafe_flag = failsafe_q;
            r.lost_total    = lost_cnt;
            r.error_total   = err_cnt;
            r.last_of_frame = (k == CHANNEL_COUNT - 1);
            expected_chans_q.push_back(r);
        end
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got, inout bit bad);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            bad = 1'b1;
        end
    endtask

    task automatic check_beat();
        chan_result_t want;
        bit           bad;
        if (expected_chans_q.size() == 0) begin
            $display("%0t: result beat for chan %0d with nothing expected",
                     $time, m_chan_index);
            fail_count++;
            return;
        end
        want = expected_chans_q.pop_front();
        bad  = 1'b0;
        cmp_field("chan_index",    32'(want.chan_index),    32'(m_chan_index),    bad);
        cmp_field("raw_value",     32'(want.raw_value),     32'(m_raw_value),     bad);
        cmp_field("scaled_value",  32'(want.scaled_value),  32'(m_scaled_value),  bad);
        cmp_field("frame_ok",      32'(want.frame_ok),      32'(m_frame_ok),      bad);
        cmp_field("failsafe_flag", 32'(want.failsafe_flag), 32'(m_failsafe_flag), bad);
        cmp_field("lost_total",    want.lost_total,         m_lost_total,         bad);
        cmp_field("error_total",   want.error_total,        m_error_total,        bad);
        cmp_field("last_of_frame", 32'(want.last_of_frame), 32'(m_last_of_frame), bad);
        if (bad) fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos   = '0;
            failsafe_q = 1'b0;
            lost_cnt   = '0;
            err_cnt    = '0;
            clip_lo    = sfd_pkg::CLIP_LOW_RST;
            clip_hi    = sfd_pkg::CLIP_HIGH_RST;
            for (int k = 0; k < CHANNEL_COUNT; k++) chan_val[k] = '0;
            expected_chans_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sfd_pkg::REG_CLIP_LOW:  clip_lo = cfg_data;
                    sfd_pkg::REG_CLIP_HIGH: clip_hi = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) decode_byte(s_rx_byte, s_frame_start);
            if (m_valid && m_ready) check_beat();
        end
        pending <= expected_chans_q.size();
    end

endmodule

[dv/sbus_frame_decoder_tb.sv]
module sbus_frame_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 5;
    // margin after the last expected result beat has been taken
    localparam int DRAIN_CYCLES = 8;
    // long receiver hold-off, enough for the frame queue to back up
    localparam int HOLD_CYCLES  = 600;
    localparam int RAND_BYTES   = 20;
    localparam int CLIP_PHASES  = 4;
    localparam int WATCHDOG_NS  = CLK_PERIOD * 200000;
    localparam int FL           = sfd_pkg::FRAME_LEN;
    localparam int IDX_W        = sfd_pkg::CFG_IDX_W;

    typedef enum int {
        FR_GOOD,
        FR_ZERO,
        FR_FULL,
        FR_BAD_START,
        FR_BAD_STOP
    } frame_kind_t;

    // every input starts at a known value
    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [7:0]       s_rx_byte     = '0;
    logic             s_frame_start = 1'b0;
    logic             cfg_valid     = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index     = '0;
    logic [10:0]      cfg_data      = '0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic [4:0]       m_chan_index;
    logic [10:0]      m_raw_value;
    logic [9:0]       m_scaled_value;
    logic             m_frame_ok;
    logic             m_failsafe_flag;
    logic [31:0]      m_lost_total;
    logic [31:0]      m_error_total;
    logic             m_last_of_frame;

    int fail_count;
    int pending;

    // pacing knobs for the sender and the receiver
    int tx_gap_max   = 18;
    int rx_stall_max = 18;
    bit rx_hold_req  = 1'b0;
    // byte position known to be zero (a whole frame just went in)
    bit aligned      = 1'b1;
    int bytes_sent   = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    sbus_frame_decoder u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_frame_start   (s_frame_start),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chan_index    (m_chan_index),
        .m_raw_value     (m_raw_value),
        .m_scaled_value  (m_scaled_value),
        .m_frame_ok      (m_frame_ok),
        .m_failsafe_flag (m_failsafe_flag),
        .m_lost_total    (m_lost_total),
        .m_error_total   (m_error_total),
        .m_last_of_frame (m_last_of_frame)
    );

    // watches all three channels, predicts and compares
    sbus_frame_decoder_checker u_checker (.*);

    // offer one byte beat after a random gap, hold it until taken
    task automatic put_byte(input logic [7:0] rx, input logic start);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_rx_byte     <= rx;
        s_frame_start <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // one frame with random content, shaped by kind; only the first
    // n_bytes go out, so a short count leaves a broken frame behind
    task automatic send_frame(input frame_kind_t kind, input logic use_start,
                              input int n_bytes);
        logic [7:0] fr [FL];
        int         i;
        for (i = 0; i < FL; i++) fr[i] = 8'($urandom_range(0, 255));
        fr[0]    = sfd_pkg::START_MARK;
        fr[FL-1] = sfd_pkg::STOP_MARK;
        case (kind)
            // every channel and every flag at zero
            FR_ZERO: for (i = 1; i < FL - 1; i++) fr[i] = 8'h00;
            // every channel at full scale, lost and failsafe set
            FR_FULL: for (i = 1; i < FL - 1; i++) fr[i] = 8'hFF;
            FR_BAD_START: begin
                while (fr[0] == sfd_pkg::START_MARK) fr[0] = 8'($urandom_range(0, 255));
            end
            FR_BAD_STOP: fr[FL-1] = 8'($urandom_range(1, 255));
            default: ;
        endcase
        for (i = 0; i < n_bytes; i++) put_byte(fr[i], (i == 0) ? use_start : 1'b0);
        aligned = (n_bytes == FL);
    endtask

    // stray bytes, now and then with a start marker in the middle
    task automatic send_noise(input int n_bytes);
        repeat (n_bytes) put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        aligned = 1'b0;
    endtask

    // mostly well-formed frames, the rest bad marks, noise and cut frames
    task automatic random_traffic(input int n_bytes);
        int   first;
        int   pick;
        logic use_start;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) begin
            pick      = $urandom_range(0, 9);
            // an unaligned decoder needs the marker to find the frame
            use_start = aligned ? 1'($urandom_range(0, 1)) : 1'b1;
            if (pick <= 6)
                send_frame(FR_GOOD, use_start, FL);
            else if (pick == 7)
                send_frame($urandom_range(0, 1) ? FR_BAD_START : FR_BAD_STOP,
                           use_start, FL);
            else if (pick == 8)
                send_noise($urandom_range(1, 30));
            else
                send_frame(FR_GOOD, 1'b1, $urandom_range(1, FL - 1));
        end
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // clip bounds plus one write to an index the block drops
    task automatic set_clips(input logic [10:0] lo, input logic [10:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= sfd_pkg::REG_CLIP_LOW;
        cfg_data  <= lo;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= sfd_pkg::REG_CLIP_HIGH;
        cfg_data  <= hi;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= IDX_W'($urandom_range(int'(sfd_pkg::REG_CLIP_HIGH) + 1,
                                           (1 << IDX_W) - 1));
        cfg_data  <= 11'($urandom_range(0, 2047));
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stall per beat, or one long hold-off on request
    initial begin
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                n           = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                n = $urandom_range(0, rx_stall_max);
            end
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        logic [10:0] lo;
        logic [10:0] hi;
        int          ph;
        // back-pressure from the start: receiver holds off while the directed
        // frames go in back to back, so the frame queue fills and the input stalls
        tx_gap_max  = 0;
        rx_hold_req = 1'b1;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes of content, both bad marks, realignment by
        // count and by marker, and a frame cut off by a new start
        send_frame(FR_ZERO,      1'b1, FL);
        send_frame(FR_FULL,      1'b0, FL);
        send_frame(FR_BAD_START, 1'b1, FL);
        send_frame(FR_BAD_STOP,  1'b1, FL);
        send_frame(FR_GOOD,      1'b1, 9);
        send_frame(FR_GOOD,      1'b1, FL);
        drain();

        // random traffic under a sweep of clip bounds, block idle at each write
        for (ph = 0; ph < CLIP_PHASES; ph++) begin
            case (ph)
                0: begin lo = 11'd0;    hi = 11'd2047; end
                1: begin lo = 11'd2047; hi = 11'd0;    end  // crossed bounds
                2: begin lo = 11'd1000; hi = 11'd1000; end
                default: begin
                    lo = 11'($urandom_range(0, 2047));
                    hi = 11'($urandom_range(0, 2047));
                end
            endcase
            // vary pacing, including stretches with no idling on either side
            case (ph % 4)
                0: begin tx_gap_max = 18; rx_stall_max = 18; end
                1: begin tx_gap_max = 0;  rx_stall_max = 0;  end
                2: begin tx_gap_max = 18; rx_stall_max = 0;  end
                default: begin tx_gap_max = 0; rx_stall_max = 18; end
            endcase
            set_clips(lo, hi);
            random_traffic(RAND_BYTES);
            drain();
        end

        if (fail_count == 0)
            $display("sbus_frame_decoder_tb: PASS");
        else
            $display("sbus_frame_decoder_tb: FAIL");
        $finish;
    end

    // hang guard
    initial begin
        #(WATCHDOG_NS);
        $display("sbus_frame_decoder_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/sfd_pkg.sv
rtl/core/sfd_front.sv
rtl/core/sfd_queue.sv
rtl/core/sfd_back.sv
rtl/core/sbus_frame_decoder.sv
rtl/core/sfd_checker.sv
dv/sbus_frame_decoder_checker.sv
dv/sbus_frame_decoder_tb.sv
